// ===== rtl/badc_pkg.sv =====
// ----------------------------------------------------------------------------
// badc_pkg
// shared types and constants for the bridge converter serial reader
// ----------------------------------------------------------------------------
package badc_pkg;

    localparam int DATA_BITS = 24;
    localparam int TAG_W     = 2;
    localparam int PHASE_W   = 6;
    localparam int GAIN_W    = 2;
    localparam int CFG_W     = 2;
    localparam int LOST_W    = 32;

    // item opcodes
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_POP        = 2'd1,
        OP_CLEAR_LOST = 2'd2
    } t_opcode;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_GAIN_PULSES = 2'd0,
        REG_LISTENING   = 2'd1,
        REG_POWER_DOWN  = 2'd2,
        REG_READY_LEVEL = 2'd3
    } t_cfg_idx;

    // finished sample headed for the fifo
    typedef struct packed {
        logic                 vld;
        logic [TAG_W-1:0]     tag;
        logic [DATA_BITS-1:0] value;
    } t_push;

    // pop result from the fifo
    typedef struct packed {
        logic                 vld;
        logic [TAG_W-1:0]     tag;
        logic [DATA_BITS-1:0] value;
    } t_pop;

endpackage

// ===== rtl/bridge_adc_serial_reader_fifo.sv =====
// ----------------------------------------------------------------------------
// bridge_adc_serial_reader_fifo
// serial reader for a 24-bit bridge converter with a sample fifo
// ----------------------------------------------------------------------------
// path: input beat to result beat through the input register and the result
//   register, with one result beat for every input beat
// throughput: one beat per cycle while the result side takes beats; the sequencer and fifo update in one pass
// reset: synchronous, active low; config to defaults, sequencer idle,
//   fifo empty, lost counter zero; store contents are not cleared
// ----------------------------------------------------------------------------
module bridge_adc_serial_reader_fifo #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  badc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [badc_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // dout
    input  logic [1:0]                          s_axis_tuser,  // opcode
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sck, sample_valid, sample_value, sample_tag, pop_valid, pop_value,
    // pop_tag, fifo_count, lost_count, zero fill
    output logic [((88 + $clog2(FIFO_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import badc_pkg::*;

    localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_BITS = 1 + 1 + DATA_BITS + TAG_W + 1 + DATA_BITS + TAG_W
                              + CNT_W + LOST_W;
    localparam int OUT_W    = ((88 + CNT_W + 7) / 8) * 8;

    // pipeline control
    logic               w_adv;      // result register can take a new beat
    logic               w_en;       // an item is processed this cycle
    logic               r_in_vld;
    t_opcode            r_in_op;
    logic               r_in_dout;
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;

    // per-item results
    logic                 w_sck;
    logic                 w_s_valid;
    logic [DATA_BITS-1:0] w_s_value;
    logic [TAG_W-1:0]     w_s_tag;
    t_push                w_push;
    t_pop                 w_pop;
    logic [CNT_W-1:0]     w_count;
    logic [LOST_W-1:0]    w_lost;
    logic [OUT_BITS-1:0]  w_res;

    // result register frees up when empty or when the beat is taken
    assign w_adv         = ~r_out_vld | m_axis_tready;
    assign w_en          = w_adv & r_in_vld;
    // input register refills whenever it moves on or sits empty
    assign s_axis_tready = w_adv | ~r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_op   <= t_opcode'(s_axis_tuser);
            r_in_dout <= s_axis_tdata[0];
        end
    end

    // serial sequencer; state moves on a processed item or on a power-down register write
    badc_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_en           (w_en),
        .i_opcode       (r_in_op),
        .i_dout         (r_in_dout),
        .o_sck          (w_sck),
        .o_sample_valid (w_s_valid),
        .o_sample_value (w_s_value),
        .o_sample_tag   (w_s_tag),
        .o_push         (w_push)
    );

    // sample store with head prefetch and overflow drop
    badc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_opcode (r_in_op),
        .i_push   (w_push),
        .o_pop    (w_pop),
        .o_count  (w_count),
        .o_lost   (w_lost)
    );

    // result packing, first field in the lowest bits
    assign w_res = {w_lost, w_count, w_pop.tag, w_pop.value, w_pop.vld,
                    w_s_tag, w_s_value, w_s_valid, w_sck};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= OUT_W'(w_res);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/badc_serial.sv =====
// ----------------------------------------------------------------------------
// badc_serial
// serial clock sequencer, bit shifter and configuration registers
// ----------------------------------------------------------------------------
module badc_serial (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  badc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [badc_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_en,
    input  badc_pkg::t_opcode                   i_opcode,
    input  logic                                i_dout,
    output logic                                o_sck,
    output logic                                o_sample_valid,
    output logic [badc_pkg::DATA_BITS-1:0]      o_sample_value,
    output logic [badc_pkg::TAG_W-1:0]          o_sample_tag,
    output badc_pkg::t_push                     o_push
);
    import badc_pkg::*;

    localparam logic [PHASE_W-1:0] SHIFT_END = PHASE_W'(2 * DATA_BITS);

    logic [GAIN_W-1:0]    r_gain;
    logic                 r_listening;
    logic                 r_power_down;
    logic                 r_ready_level;
    logic [PHASE_W-1:0]   r_phase,  n_phase;
    logic [DATA_BITS-1:0] r_shift,  n_shift;
    logic [TAG_W-1:0]     r_prev,   n_prev;
    logic                 r_was_pd;
    logic [PHASE_W-1:0]   w_end;

    assign w_end = SHIFT_END + PHASE_W'({r_gain, 1'b0});

    always_comb begin
        n_phase        = r_phase;
        n_shift        = r_shift;
        n_prev         = r_prev;
        o_sck          = 1'b0;
        o_sample_valid = 1'b0;
        o_sample_value = '0;
        o_sample_tag   = '0;
        if (i_opcode == OP_TICK) begin
            if (r_power_down) begin
                o_sck = 1'b1;
            end else if (r_phase == '0) begin
                if (i_dout == r_ready_level) begin
                    n_phase = PHASE_W'(1);
                    n_shift = '0;
                end
            end else if (r_phase[0]) begin
                o_sck = 1'b1;
                if (r_phase < SHIFT_END) begin
                    n_shift = {r_shift[DATA_BITS-2:0], i_dout};
                end
                n_phase = r_phase + PHASE_W'(1);
            end else if (r_phase >= w_end) begin
                // last low half: word done, tag with old selection
                o_sample_valid = 1'b1;
                o_sample_value = r_shift;
                o_sample_tag   = r_prev;
                n_prev         = r_gain;
                n_phase        = '0;
                n_shift        = '0;
            end else begin
                n_phase = r_phase + PHASE_W'(1);
            end
        end else begin
            // clock holds the level of the last tick
            o_sck = r_power_down | ((r_phase != '0) & ~r_phase[0]);
        end
    end

    assign o_push.vld   = i_en & o_sample_valid & r_listening;
    assign o_push.tag   = o_sample_tag;
    assign o_push.value = o_sample_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= GAIN_W'(1);
            r_listening   <= 1'b0;
            r_power_down  <= 1'b0;
            r_ready_level <= 1'b1;
            r_phase       <= '0;
            r_shift       <= '0;
            r_prev        <= TAG_W'(1);
            r_was_pd      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_PULSES: begin
                    if (i_cfg_data != '0) begin
                        r_gain <= i_cfg_data;
                    end
                end
                REG_LISTENING: begin
                    r_listening <= i_cfg_data[0];
                end
                REG_POWER_DOWN: begin
                    r_power_down <= i_cfg_data[0];
                    if (i_cfg_data[0]) begin
                        // abort any read in flight
                        r_was_pd <= 1'b1;
                        r_phase  <= '0;
                        r_shift  <= '0;
                    end else if (r_was_pd) begin
                        r_prev   <= TAG_W'(1);
                        r_was_pd <= 1'b0;
                    end
                end
                REG_READY_LEVEL: begin
                    r_ready_level <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_en) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_prev  <= n_prev;
        end
    end

endmodule

// ===== rtl/badc_fifo.sv =====
// ----------------------------------------------------------------------------
// badc_fifo
// sample fifo that drops its oldest entry on overflow, with lost counter
// ----------------------------------------------------------------------------
module badc_fifo #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  badc_pkg::t_opcode                         i_opcode,
    input  badc_pkg::t_push                           i_push,
    output badc_pkg::t_pop                            o_pop,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]           o_count,
    output logic [badc_pkg::LOST_W-1:0]               o_lost
);
    import badc_pkg::*;

    localparam int IDX_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int ENTRY_W = TAG_W + DATA_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

    logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
    logic [ENTRY_W-1:0] r_head_q;
    logic [IDX_W-1:0]   r_head,    n_head;
    logic [CNT_W-1:0]   r_held,    n_held;
    logic [LOST_W-1:0]  r_dropped, n_dropped;
    logic [CNT_W:0]     w_sum;
    logic [IDX_W-1:0]   w_slot;
    logic [IDX_W-1:0]   w_head_inc;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_entry;

    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
    // tail slot, wrapped by one compare and subtract
    assign w_sum      = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_held);
    assign w_slot     = (w_sum >= DEPTH_S) ? IDX_W'(w_sum - DEPTH_S) : IDX_W'(w_sum);
    assign w_pop      = i_en & (i_opcode == OP_POP) & (r_held != '0);
    assign w_entry    = {i_push.tag, i_push.value};

    always_comb begin
        n_head    = r_head;
        n_held    = r_held;
        n_dropped = r_dropped;
        o_pop     = '0;
        if (w_pop) begin
            o_pop.vld   = 1'b1;
            o_pop.tag   = r_head_q[ENTRY_W-1:DATA_BITS];
            o_pop.value = r_head_q[DATA_BITS-1:0];
            n_head      = w_head_inc;
            n_held      = r_held - CNT_W'(1);
        end else if (i_push.vld) begin
            if (r_held == DEPTH_C) begin
                n_head = w_head_inc;
                if (r_dropped != '1) begin
                    n_dropped = r_dropped + LOST_W'(1);
                end
            end else begin
                n_held = r_held + CNT_W'(1);
            end
        end else if (i_en && (i_opcode == OP_CLEAR_LOST)) begin
            n_dropped = '0;
        end
    end

    assign o_count = n_held;
    assign o_lost  = n_dropped;

    // store and head prefetch; a write landing on the new head is forwarded
    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            mem[w_slot] <= w_entry;
        end
        if (i_push.vld && (w_slot == n_head)) begin
            r_head_q <= w_entry;
        end else begin
            r_head_q <= mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_held    <= '0;
            r_dropped <= '0;
        end else begin
            r_head    <= n_head;
            r_held    <= n_held;
            r_dropped <= n_dropped;
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bridge_adc_serial_reader_fifo: random tick, pop,
// clear-lost and reserved beats, a beat-level predictor of the serial read
// sequencer and sample fifo, and random idling on both stream sides
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import badc_pkg::*;

    localparam int STORE_DEPTH    = 8;
    localparam int CLK_HALF       = 6;
    localparam int LATENCY        = 2;
    localparam int IDLE_PCT       = 34;
    localparam int NUM_PHASES     = 30;
    localparam int TIMEOUT_CYCLES = 100000;
    localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
    localparam int OUT_W          = ((88 + CNT_W + 7) / 8) * 8;

    // opcode value the block must leave alone
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // dout patterns for one run of beats
    localparam int DOUT_RANDOM = 0;
    localparam int DOUT_ONES   = 1;
    localparam int DOUT_ZEROS  = 2;

    // one result beat, last field (sck) in the lowest bits
    typedef struct packed {
        logic [LOST_W-1:0]    lost_count;
        logic [CNT_W-1:0]     fifo_count;
        logic [TAG_W-1:0]     pop_tag;
        logic [DATA_BITS-1:0] pop_value;
        logic                 pop_valid;
        logic [TAG_W-1:0]     sample_tag;
        logic [DATA_BITS-1:0] sample_value;
        logic                 sample_valid;
        logic                 sck;
    } t_reader_beat;

    typedef struct packed {
        logic [1:0] op;
        logic       dout;
    } t_serial_item;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [DATA_BITS-1:0] value;
    } t_stored_sample;

    // ------------------------------------------------------------------------
    // dut hookup, every input known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    t_cfg_idx          i_cfg_idx     = REG_GAIN_PULSES;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // dout, zero fill
    logic [1:0]        s_axis_tuser  = '0;   // opcode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // sck, sample_valid, sample_value, sample_tag, pop_valid, pop_value,
    // pop_tag, fifo_count, lost_count, zero fill
    logic [OUT_W-1:0]  m_axis_tdata;

    bridge_adc_serial_reader_fifo #(
        .FIFO_DEPTH (STORE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor state: register copies, read sequencer, sample fifo
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0]    cfg_gain;
    logic                 cfg_listen;
    logic                 cfg_pdown;
    logic                 cfg_ready;

    logic [PHASE_W-1:0]   seq_phase;
    logic [DATA_BITS-1:0] shift_acc;
    logic [TAG_W-1:0]     last_sel;
    logic                 pd_latched;
    t_stored_sample       sample_fifo [STORE_DEPTH];
    logic [2:0]           fifo_head;
    logic [CNT_W-1:0]     fifo_held;
    logic [LOST_W-1:0]    lost_total;

    t_serial_item         stim_items [$];
    t_reader_beat         due_results [$];

    logic                 in_taken = 1'b0;
    logic                 no_gaps  = 1'b0;
    logic                 failed   = 1'b0;

    function automatic void reset_reader_model();
        cfg_gain   = 2'd1;
        cfg_listen = 1'b0;
        cfg_pdown  = 1'b0;
        cfg_ready  = 1'b1;
        seq_phase  = '0;
        shift_acc  = '0;
        last_sel   = 2'd1;
        pd_latched = 1'b0;
        fifo_head  = '0;
        fifo_held  = '0;
        lost_total = '0;
    endfunction

    function automatic void apply_reg_write(t_cfg_idx idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_GAIN_PULSES: begin
                // zero is out of range and leaves the gain alone
                if (data != 0)
                    cfg_gain = data;
            end
            REG_LISTENING: cfg_listen = data[0];
            REG_POWER_DOWN: begin
                cfg_pdown = data[0];
                if (cfg_pdown) begin
                    // power down aborts any read in progress
                    pd_latched = 1'b1;
                    seq_phase  = '0;
                    shift_acc  = '0;
                end else if (pd_latched) begin
                    // waking up resets the selection the chip is on
                    last_sel   = 2'd1;
                    pd_latched = 1'b0;
                end
            end
            REG_READY_LEVEL: cfg_ready = data[0];
            default: ;
        endcase
    endfunction

    // works out the result beat for one accepted input beat
    function automatic void compute_reader_beat(logic [1:0] op, logic din);
        t_reader_beat   r;
        t_stored_sample ent;
        int             end_phase;
        logic [2:0]     slot;
        r = '0;
        if (op == OP_TICK) begin
            end_phase = 2 * (DATA_BITS + int'(cfg_gain));
            if (cfg_pdown) begin
                r.sck = 1'b1;
            end else if (seq_phase == 0) begin
                // idle: start a read when dout shows ready
                if (din == cfg_ready) begin
                    seq_phase = PHASE_W'(1);
                    shift_acc = '0;
                end
            end else if (seq_phase[0]) begin
                // high half of a pulse, data bits on the first 24 pulses
                r.sck = 1'b1;
                if (int'(seq_phase) < 2 * DATA_BITS)
                    shift_acc = {shift_acc[DATA_BITS-2:0], din};
                seq_phase = seq_phase + 1'b1;
            end else if (int'(seq_phase) >= end_phase) begin
                // last low half: word done, tagged with the old selection
                r.sample_valid = 1'b1;
                r.sample_value = shift_acc;
                r.sample_tag   = last_sel;
                last_sel       = cfg_gain;
                if (cfg_listen) begin
                    slot = fifo_head + fifo_held[2:0];
                    sample_fifo[slot] = '{tag: r.sample_tag, value: r.sample_value};
                    if (fifo_held < STORE_DEPTH) begin
                        fifo_held = fifo_held + 1'b1;
                    end else begin
                        // full: oldest entry is overwritten and counted lost
                        fifo_head = fifo_head + 1'b1;
                        if (lost_total != '1)
                            lost_total = lost_total + 1'b1;
                    end
                end
                seq_phase = '0;
                shift_acc = '0;
            end else begin
                seq_phase = seq_phase + 1'b1;
            end
        end else begin
            // no clock advance, sck holds the level of the last tick
            r.sck = cfg_pdown | (seq_phase != 0 && !seq_phase[0]);
            if (op == OP_POP) begin
                if (fifo_held != 0) begin
                    ent         = sample_fifo[fifo_head];
                    r.pop_valid = 1'b1;
                    r.pop_value = ent.value;
                    r.pop_tag   = ent.tag;
                    fifo_head   = fifo_head + 1'b1;
                    fifo_held   = fifo_held - 1'b1;
                end
            end else if (op == OP_CLEAR_LOST) begin
                lost_total = '0;
            end
        end
        r.fifo_count = fifo_held;
        r.lost_count = lost_total;
        due_results.push_back(r);
    endfunction

    function automatic void compare_field(string fname, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            failed = 1'b1;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: falling edge, fed from stim_items
    // ------------------------------------------------------------------------
    t_serial_item drv_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (stim_items.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drv_item = stim_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, drv_item.dout};
                s_axis_tuser  <= drv_item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // monitor: rising edge, predicts input beats and checks result beats
    // ------------------------------------------------------------------------
    t_reader_beat mon_got;
    t_reader_beat mon_want;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            compute_reader_beat(s_axis_tuser, s_axis_tdata[0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = t_reader_beat'(m_axis_tdata[$bits(t_reader_beat)-1:0]);
            if (due_results.size() == 0) begin
                failed = 1'b1;
                $display("%0t ns: result beat expected none, actual 0x%0h",
                         $time, mon_got);
            end else begin
                mon_want = due_results.pop_front();
                compare_field("sck", 32'(mon_want.sck), 32'(mon_got.sck));
                compare_field("sample_valid", 32'(mon_want.sample_valid),
                              32'(mon_got.sample_valid));
                compare_field("sample_value", 32'(mon_want.sample_value),
                              32'(mon_got.sample_value));
                compare_field("sample_tag", 32'(mon_want.sample_tag),
                              32'(mon_got.sample_tag));
                compare_field("pop_valid", 32'(mon_want.pop_valid),
                              32'(mon_got.pop_valid));
                compare_field("pop_value", 32'(mon_want.pop_value),
                              32'(mon_got.pop_value));
                compare_field("pop_tag", 32'(mon_want.pop_tag),
                              32'(mon_got.pop_tag));
                compare_field("fifo_count", 32'(mon_want.fifo_count),
                              32'(mon_got.fifo_count));
                compare_field("lost_count", mon_want.lost_count, mon_got.lost_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_item(logic [1:0] op, logic d);
        stim_items.push_back('{op: op, dout: d});
    endtask

    // all beats taken, all results seen, then let the pipeline settle
    task automatic wait_idle();
        while (stim_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly ticks so reads run to the end, pops and clears sprinkled in
    task automatic fill_run(int n, int pop_pct, int clr_pct, int dmode);
        int         roll;
        logic [1:0] op;
        logic       d;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < pop_pct)
                op = OP_POP;
            else if (roll < pop_pct + clr_pct)
                op = OP_CLEAR_LOST;
            else if (roll < pop_pct + clr_pct + 2)
                op = OP_RESERVED;
            else
                op = OP_TICK;
            case (dmode)
                DOUT_ONES:  d = 1'b1;
                DOUT_ZEROS: d = 1'b0;
                default:    d = 1'($urandom_range(0, 1));
            endcase
            add_item(op, d);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int n_items;
    int pop_pct;
    int dmode;
    int roll;

    initial begin
        reset_reader_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, clear, reserved opcode, not-ready and ready
        // ticks, pop with sck held high mid read
        add_item(OP_POP, 1'b0);
        add_item(OP_CLEAR_LOST, 1'b1);
        add_item(OP_RESERVED, 1'b1);
        add_item(OP_TICK, 1'b0);
        add_item(OP_TICK, 1'b0);
        add_item(OP_RESERVED, 1'b0);
        add_item(OP_TICK, 1'b1);
        add_item(OP_TICK, 1'b1);
        add_item(OP_POP, 1'b1);
        add_item(OP_TICK, 1'b0);
        add_item(OP_POP, 1'b0);
        add_item(OP_TICK, 1'b1);
        add_item(OP_CLEAR_LOST, 1'b0);
        add_item(OP_TICK, 1'b1);
        wait_idle();

        // power down in the middle of a read, then wake up
        write_reg(REG_POWER_DOWN, 2'b01);
        add_item(OP_TICK, 1'b1);
        add_item(OP_POP, 1'b0);
        add_item(OP_TICK, 1'b0);
        add_item(OP_RESERVED, 1'b1);
        wait_idle();
        write_reg(REG_POWER_DOWN, 2'b00);
        // out of range gain, must be ignored
        write_reg(REG_GAIN_PULSES, 2'd0);
        add_item(OP_TICK, 1'b1);
        add_item(OP_TICK, 1'b0);

        // random phases, registers rewritten between them while idle
        for (int k = 0; k < NUM_PHASES; k++) begin
            wait_idle();

            // gain: fixed values forced on a few phases, sometimes random elsewhere
            if (k == 0)
                write_reg(REG_GAIN_PULSES, 2'd3);
            else if (k == 3)
                write_reg(REG_GAIN_PULSES, 2'd0);
            else if (k == 6)
                write_reg(REG_GAIN_PULSES, 2'd1);
            else if (k == 8)
                write_reg(REG_GAIN_PULSES, 2'd2);
            else if ($urandom_range(0, 9) < 4)
                write_reg(REG_GAIN_PULSES, 2'($urandom_range(0, 3)));

            // listening, upper data bit random and meaningless
            write_reg(REG_LISTENING,
                      {1'($urandom_range(0, 1)),
                       !(k == 2 || k == 17 || k == 18) || k == 5});

            // two power-down windows, plus a wake write with no sleep before
            if (k == 9 || k == 21)
                write_reg(REG_POWER_DOWN, {1'($urandom_range(0, 1)), 1'b1});
            else if (k == 10 || k == 22)
                write_reg(REG_POWER_DOWN, 2'b00);
            else if (k == 20)
                write_reg(REG_POWER_DOWN, 2'b10);

            if (k == 12)
                write_reg(REG_READY_LEVEL, 2'b10);
            else if (k == 24)
                write_reg(REG_READY_LEVEL, 2'b01);
            else if ($urandom_range(0, 3) == 0)
                write_reg(REG_READY_LEVEL, 2'($urandom_range(0, 3)));

            // a long stretch with no idling on either side
            no_gaps = (k >= 14 && k <= 16);

            roll = $urandom_range(0, 9);
            dmode = (roll < 6) ? DOUT_RANDOM : (roll < 8) ? DOUT_ONES : DOUT_ZEROS;

            if (k == 5) begin
                // many samples with no pops, fifo overflows and drops
                fill_run(700, 0, 0, DOUT_RANDOM);
            end else begin
                // drain the fifo hard right after the overflow run
                pop_pct = (k == 6) ? 30 : $urandom_range(1, 8);
                n_items = $urandom_range(25, 55);
                fill_run(n_items, pop_pct, 3, dmode);
            end
        end

        wait_idle();
        if (!failed) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/badc_pkg.sv
rtl/badc_serial.sv
rtl/badc_fifo.sv
rtl/bridge_adc_serial_reader_fifo.sv
sim/tb.sv
